@@ hw/rtl/udpdmx_pkg.sv @@
// Package for the UDP port demultiplexer: operation and status codes,
// header constants and the request type passed from front to back.
// No dependencies.
`default_nettype none
package udpdmx_pkg;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_BIND   = 2'd1,
        OP_UNBIND = 2'd2,
        OP_RECV   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_DROP     = 4'd1,
        ST_BADPORT  = 4'd2,
        ST_EMPTY    = 4'd3,
        ST_PERR     = 4'd4,
        ST_ARP      = 4'd5,
        ST_ECHO     = 4'd6,
        ST_NOTIFIED = 4'd7,
        ST_IGNORED  = 4'd8
    } status_t;

    // What the back end must do with a classified request.
    typedef enum logic [2:0] {
        ACT_DONE   = 3'd0,
        ACT_UDP    = 3'd1,
        ACT_ICMP   = 3'd2,
        ACT_BIND   = 3'd3,
        ACT_UNBIND = 3'd4,
        ACT_RECV   = 3'd5
    } act_t;

    // Back end sequencing.
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_PORT   = 2'd1,
        BK_FINISH = 2'd2
    } back_state_t;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  ICMP_TYPE_ECHO = 8'd8;
    localparam logic [7:0]  ICMP_UNREACH = 8'd3;
    localparam logic [7:0]  ICMP_TIMEX = 8'd11;
    localparam logic [7:0]  ICMP_TYPE_QUENCH = 8'd4;
    localparam logic [11:0] ARP_MIN_LEN = 12'd42;
    localparam logic [11:0] IP_MIN_LEN  = 12'd34;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    typedef struct packed {
        act_t        act;
        status_t     status;
        logic [15:0] port;
        logic [15:0] src_port;
        logic [31:0] src_ip;
        logic [12:0] plen;
        logic [15:0] max_len;
    } req_t;

endpackage
`default_nettype wire

@@ hw/rtl/udpdmx_front.sv @@
// Front end: accepts requests, checks headers and settles all outcomes that
// need no per-port state. Handles the ARP answered flag. Uses udpdmx_pkg.
`default_nettype none
module udpdmx_front
    import udpdmx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [1:0]  op,
    input  wire logic [11:0] frame_len,
    input  wire logic [15:0] ethertype,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [3:0]  ihl,
    input  wire logic [15:0] port,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] udp_len,
    input  wire logic [31:0] src_ip,
    input  wire logic [7:0]  icmp_type,
    input  wire logic [15:0] inner_port,
    input  wire logic [15:0] max_len,
    input  wire logic        accept,
    output req_t             req
);

    logic        arp_done_reg;
    logic        arp_done_next;
    logic [12:0] min_len;
    logic [15:0] pay;

    always_comb
    begin
        min_len = 13'd22 + {7'd0, ihl, 2'b00};
        pay = (udp_len >= UDP_HDR_LEN) ? udp_len - UDP_HDR_LEN : 16'd0;
        arp_done_next = arp_done_reg;
        req.act = ACT_DONE;
        req.status = ST_OK;
        req.port = port;
        req.src_port = src_port;
        req.src_ip = src_ip;
        req.max_len = max_len;
        req.plen = (pay > 16'(MAX_PAYLOAD)) ? 13'(MAX_PAYLOAD) : pay[12:0];
        unique case (op_t'(op))
            OP_BIND:   req.act = ACT_BIND;
            OP_UNBIND: req.act = ACT_UNBIND;
            OP_RECV:   req.act = ACT_RECV;
            OP_PACKET:
            begin
                priority if (frame_len >= ARP_MIN_LEN && ethertype == ETYPE_ARP)
                begin
                    req.status = arp_done_reg ? ST_DROP : ST_ARP;
                    arp_done_next = 1'b1;
                end
                else if (!(frame_len >= IP_MIN_LEN && ethertype == ETYPE_IPV4))
                    req.status = ST_DROP;
                else if ({1'b0, frame_len} < min_len)
                    req.status = ST_DROP;
                else if (ip_protocol == PROTO_ICMP)
                begin
                    priority if (icmp_type == ICMP_TYPE_ECHO)
                        req.status = ST_ECHO;
                    else if (icmp_type == ICMP_UNREACH || icmp_type == ICMP_TIMEX
                             || icmp_type == ICMP_TYPE_QUENCH)
                    begin
                        req.act = ACT_ICMP;
                        req.port = inner_port;
                    end
                    else
                        req.status = ST_DROP;
                end
                else if (ip_protocol != PROTO_UDP || ihl < 4'd5)
                    req.status = ST_DROP;
                else
                    req.act = ACT_UDP;
            end
            default: req.act = ACT_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arp_done_reg <= 1'b0;
        else if (in_valid && accept)
            arp_done_reg <= arp_done_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/udpdmx_fifo.sv @@
// Two-entry request queue between front and back end.
// Uses udpdmx_pkg for the request type.
`default_nettype none
module udpdmx_fifo
    import udpdmx_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  req_t      wr_data,
    output logic      full,
    input  wire logic rd_en,
    output logic      not_empty,
    output req_t      rd_data
);

    req_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/udpdmx_back.sv @@
// Back end: per-port bound, error and pointer state and the descriptor
// memory. Each request has a port state look-up with descriptor read (BK_PORT),
// then update and result (BK_FINISH). Uses udpdmx_pkg.
`default_nettype none
module udpdmx_back
    import udpdmx_pkg::*;
#(
    parameter int PORTS = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_avail,
    input  req_t             req,
    output logic             req_take,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       status,
    output logic [9:0]       slot,
    output logic [31:0]      out_src_ip,
    output logic [15:0]      out_src_port,
    output logic [9:0]       data_len
);

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = QW + 1;
    localparam int DEPTH = PORTS * QUEUE_DEPTH;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] sport;
        logic [12:0] len;
    } desc_t;

    typedef struct packed {
        logic          bound;
        logic          err;
        logic [CW-1:0] rcnt;
        logic [CW-1:0] wcnt;
    } pstate_t;

    // A port whose valid flag is clear reads as unbound with an empty queue.
    pstate_t       pst_mem [PORTS];
    logic          pst_vld_reg [PORTS];
    desc_t         mem [DEPTH];
    desc_t         rd_reg;
    pstate_t       pst_rd_reg;
    logic          vld_rd_reg;
    logic          fwd_reg;
    pstate_t       fwd_ps_reg;
    pstate_t       ps_reg;

    back_state_t   state_reg;
    back_state_t   state_next;
    req_t          cur_reg;
    logic          inrange_reg;
    logic [PW-1:0] p_reg;

    logic [PW-1:0] p_in;
    logic          inr_in;
    pstate_t       ps;
    pstate_t       ps_new;
    logic          ps_we;
    logic          desc_we;
    logic          done;
    logic [CW-1:0] occ;
    logic [9:0]    wslot, rslot;
    logic          ob_full;
    logic [3:0]    res_status;
    logic [9:0]    res_slot;
    logic [31:0]   res_ip;
    logic [15:0]   res_sport;
    logic [9:0]    res_len;

    assign p_in = req.port[PW-1:0];
    assign inr_in = {16'd0, req.port} < 32'(PORTS);
    assign ob_full = out_valid && out_stall;
    // A request taken as the previous one finishes on the same port sees
    // the state being written rather than the stale memory word.
    assign ps = fwd_reg ? fwd_ps_reg : (vld_rd_reg ? pst_rd_reg : '0);
    assign occ = ps_reg.wcnt - ps_reg.rcnt;
    assign wslot = 10'(({22'd0, p_reg} * 32'(QUEUE_DEPTH)) + 32'(ps_reg.wcnt[QW-1:0]));
    assign rslot = 10'(({22'd0, p_reg} * 32'(QUEUE_DEPTH)) + 32'(ps_reg.rcnt[QW-1:0]));

    always_comb
    begin
        state_next = state_reg;
        req_take = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                if (req_avail)
                begin
                    req_take = 1'b1;
                    state_next = BK_PORT;
                end
            BK_PORT:
                state_next = BK_FINISH;
            BK_FINISH:
                if (!ob_full)
                begin
                    done = 1'b1;
                    if (req_avail)
                    begin
                        req_take = 1'b1;
                        state_next = BK_PORT;
                    end
                    else
                        state_next = BK_IDLE;
                end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        res_status = cur_reg.status;
        res_slot = 10'd0;
        res_ip = 32'd0;
        res_sport = 16'd0;
        res_len = 10'd0;
        ps_new = ps_reg;
        ps_we = 1'b0;
        desc_we = 1'b0;
        unique case (cur_reg.act)
            ACT_DONE: ;
            ACT_ICMP:
                if (inrange_reg && ps_reg.bound)
                begin
                    ps_new.err = 1'b1;
                    ps_we = 1'b1;
                    res_status = ST_NOTIFIED;
                end
                else
                    res_status = ST_IGNORED;
            ACT_UDP:
                if (!inrange_reg || !ps_reg.bound || occ >= CW'(QUEUE_DEPTH))
                    res_status = ST_DROP;
                else
                begin
                    res_status = ST_OK;
                    res_slot = wslot;
                    res_len = cur_reg.plen[9:0];
                    ps_new.wcnt = ps_reg.wcnt + CW'(1);
                    ps_we = 1'b1;
                    desc_we = 1'b1;
                end
            ACT_BIND, ACT_UNBIND:
                if (!inrange_reg)
                    res_status = ST_BADPORT;
                else
                begin
                    res_status = ST_OK;
                    ps_new.bound = cur_reg.act == ACT_BIND;
                    ps_new.rcnt = '0;
                    ps_new.wcnt = '0;
                    ps_we = 1'b1;
                end
            ACT_RECV:
                priority if (!inrange_reg)
                    res_status = ST_BADPORT;
                else if (ps_reg.err)
                begin
                    ps_new.err = 1'b0;
                    ps_we = 1'b1;
                    res_status = ST_PERR;
                end
                else if (occ == '0)
                    res_status = ST_EMPTY;
                else
                begin
                    res_status = ST_OK;
                    res_slot = rslot;
                    res_ip = rd_reg.ip;
                    res_sport = rd_reg.sport;
                    res_len = ({3'd0, rd_reg.len} > cur_reg.max_len)
                              ? cur_reg.max_len[9:0] : rd_reg.len[9:0];
                    ps_new.rcnt = ps_reg.rcnt + CW'(1);
                    ps_we = 1'b1;
                end
            default: res_status = ST_DROP;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cur_reg <= req;
            p_reg <= p_in;
            inrange_reg <= inr_in;
            pst_rd_reg <= pst_mem[p_in];
            fwd_ps_reg <= ps_new;
        end
        if (state_reg == BK_PORT)
        begin
            ps_reg <= ps;
            rd_reg <= mem[(PW + QW)'({p_reg, ps.rcnt[QW-1:0]})];
        end
        if (done && ps_we)
            pst_mem[p_reg] <= ps_new;
        if (done && desc_we)
            mem[(PW + QW)'({p_reg, ps_reg.wcnt[QW-1:0]})] <=
                '{ip: cur_reg.src_ip, sport: cur_reg.src_port, len: cur_reg.plen};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            vld_rd_reg <= 1'b0;
            fwd_reg <= 1'b0;
            out_valid <= 1'b0;
            status <= 4'd0;
            slot <= 10'd0;
            out_src_ip <= 32'd0;
            out_src_port <= 16'd0;
            data_len <= 10'd0;
            for (int i = 0; i < PORTS; i++)
                pst_vld_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_take)
            begin
                vld_rd_reg <= pst_vld_reg[p_in];
                fwd_reg <= done && ps_we && (p_in == p_reg);
            end
            if (done && ps_we)
                pst_vld_reg[p_reg] <= 1'b1;
            if (done)
            begin
                out_valid <= 1'b1;
                status <= res_status;
                slot <= res_slot;
                out_src_ip <= res_ip;
                out_src_port <= res_sport;
                data_len <= res_len;
            end
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/udp_port_demux_queues.sv @@
// Top level of the UDP port demultiplexer with receive queues.
// Depends on udpdmx_pkg, udpdmx_front, udpdmx_fifo and udpdmx_back.
//
//   channel | signals                           | direction
//   input   | in_valid, in_stall, op .. max_len | request in
//   output  | out_valid, out_stall, status ..   | result out
//
// In the back end each request has a port state look-up and descriptor read,
// then an update and result; the next request is taken only as the previous
// one finishes. The front end classifies in the accept cycle and a two-entry
// queue decouples it from the back end.
// Of the per-port state, reset clears only the valid flags, so every port reads
// as unbound with an empty queue; descriptors need none.
// A stalled result holds the back end; the queue then fills and stalls input.
`default_nettype none
module udp_port_demux_queues
    import udpdmx_pkg::*;
#(
    parameter int PORTS = 64,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [11:0] frame_len,
    input  wire logic [15:0] ethertype,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic [3:0]  ihl,
    input  wire logic [15:0] port,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] udp_len,
    input  wire logic [31:0] src_ip,
    input  wire logic [7:0]  icmp_type,
    input  wire logic [15:0] inner_port,
    input  wire logic [15:0] max_len,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       status,
    output logic [9:0]       slot,
    output logic [31:0]      out_src_ip,
    output logic [15:0]      out_src_port,
    output logic [9:0]       data_len
);

    req_t front_req, back_req;
    logic q_full, q_avail, q_take;

    assign in_stall = q_full;

    udpdmx_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk, .rst_n, .in_valid, .op, .frame_len, .ethertype, .ip_protocol,
        .ihl, .port, .src_port, .udp_len, .src_ip, .icmp_type, .inner_port,
        .max_len, .accept(!q_full), .req(front_req)
    );

    udpdmx_fifo u_fifo (
        .clk, .rst_n, .wr_en(in_valid && !q_full), .wr_data(front_req),
        .full(q_full), .rd_en(q_take), .not_empty(q_avail), .rd_data(back_req)
    );

    udpdmx_back #(.PORTS(PORTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk, .rst_n, .req_avail(q_avail), .req(back_req), .req_take(q_take),
        .out_valid, .out_stall, .status, .slot, .out_src_ip, .out_src_port,
        .data_len
    );

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result changed while stalled");
    a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_avail)
        else $error("back end took from empty queue");
    a_st_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 4'd8)
        else $error("status code out of range");

endmodule
`default_nettype wire

@@ verif/udp_port_demux_queues_test.sv @@
// Testbench for udp_port_demux_queues: directed and random requests are checked
// against a behavioural model of port binding, receive queues and ICMP/ARP handling.
// Depends on udpdmx_pkg and the udp_port_demux_queues RTL.
module udp_port_demux_queues_test;
    import udpdmx_pkg::*;

    localparam int NPORTS = 64;
    localparam int DEPTH = 16;
    localparam int MAXPAY = 512;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [11:0] frame_len;
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [3:0]  ihl;
    logic [15:0] port;
    logic [15:0] src_port;
    logic [15:0] udp_len;
    logic [31:0] src_ip;
    logic [7:0]  icmp_type;
    logic [15:0] inner_port;
    logic [15:0] max_len;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  status;
    logic [9:0]  slot;
    logic [31:0] out_src_ip;
    logic [15:0] out_src_port;
    logic [9:0]  data_len;

    udp_port_demux_queues dut (.*);

    typedef struct {
        op_t         op;
        logic [11:0] frame_len;
        logic [15:0] ethertype;
        logic [7:0]  ip_protocol;
        logic [3:0]  ihl;
        logic [15:0] port;
        logic [15:0] src_port;
        logic [15:0] udp_len;
        logic [31:0] src_ip;
        logic [7:0]  icmp_type;
        logic [15:0] inner_port;
        logic [15:0] max_len;
    } request_t;

    typedef struct {
        status_t     status;
        logic [9:0]  slot;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [9:0]  data_len;
    } outcome_t;

    // Shadow copy of the block's port state.
    bit          bound_q[NPORTS];
    bit          err_q[NPORTS];
    int unsigned rd_cnt[NPORTS];
    int unsigned wr_cnt[NPORTS];
    logic [31:0] desc_ip[NPORTS*DEPTH];
    logic [15:0] desc_sport[NPORTS*DEPTH];
    int unsigned desc_len[NPORTS*DEPTH];
    bit          arp_done;

    outcome_t pending_outcomes[$];
    int       failures;
    int       idle_cycles = 0;

    function automatic int unsigned fill_of(int p);
        return (wr_cnt[p] + 2*DEPTH - rd_cnt[p]) % (2*DEPTH);
    endfunction

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t    o;
        int unsigned flen;
        int unsigned hlen;
        int unsigned plen;
        int          idx;
        int          p;
        o = '{ST_OK, '0, '0, '0, '0};
        flen = r.frame_len;
        hlen = r.ihl * 4;
        p = r.port;
        if (r.op == OP_PACKET) begin
            if (flen >= ARP_MIN_LEN && r.ethertype == ETYPE_ARP) begin
                o.status = arp_done ? ST_DROP : ST_ARP;
                arp_done = 1'b1;
            end else if (!(flen >= IP_MIN_LEN && r.ethertype == ETYPE_IPV4)) begin
                o.status = ST_DROP;
            end else if (r.ip_protocol == PROTO_ICMP) begin
                if (flen < 14 + hlen + 8)
                    o.status = ST_DROP;
                else if (r.icmp_type == ICMP_TYPE_ECHO)
                    o.status = ST_ECHO;
                else if (r.icmp_type != ICMP_UNREACH && r.icmp_type != ICMP_TIMEX
                         && r.icmp_type != ICMP_TYPE_QUENCH)
                    o.status = ST_DROP;
                else if (r.inner_port < NPORTS && bound_q[r.inner_port]) begin
                    err_q[r.inner_port] = 1'b1;
                    o.status = ST_NOTIFIED;
                end else
                    o.status = ST_IGNORED;
            end else if (r.ip_protocol != PROTO_UDP || hlen < 20 || flen < 14 + hlen + 8) begin
                o.status = ST_DROP;
            end else if (p >= NPORTS || !bound_q[p] || fill_of(p) >= DEPTH) begin
                o.status = ST_DROP;
            end else begin
                plen = r.udp_len >= 8 ? r.udp_len - 8 : 0;
                if (plen > MAXPAY)
                    plen = MAXPAY;
                idx = p*DEPTH + wr_cnt[p] % DEPTH;
                desc_ip[idx] = r.src_ip;
                desc_sport[idx] = r.src_port;
                desc_len[idx] = plen;
                o.slot = 10'(idx);
                o.data_len = 10'(plen);
                wr_cnt[p] = (wr_cnt[p] + 1) % (2*DEPTH);
            end
        end else if (p >= NPORTS) begin
            o.status = ST_BADPORT;
        end else if (r.op != OP_RECV) begin
            bound_q[p] = (r.op == OP_BIND);
            rd_cnt[p] = 0;
            wr_cnt[p] = 0;
        end else if (err_q[p]) begin
            err_q[p] = 1'b0;
            o.status = ST_PERR;
        end else if (fill_of(p) == 0) begin
            o.status = ST_EMPTY;
        end else begin
            idx = p*DEPTH + rd_cnt[p] % DEPTH;
            o.slot = 10'(idx);
            o.src_ip = desc_ip[idx];
            o.src_port = desc_sport[idx];
            o.data_len = 10'(desc_len[idx] > r.max_len ? r.max_len : desc_len[idx]);
            rd_cnt[p] = (rd_cnt[p] + 1) % (2*DEPTH);
        end
        return o;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on cycles with no accepted request and no accepted result.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("udp_port_demux_queues test failed");
            $finish;
        end
    end

    // Result checker with random receiver stalls.
    initial begin : result_checker
        outcome_t exp_o;
        int       gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result with nothing expected, status %0d", status);
                    failures++;
                end else begin
                    exp_o = pending_outcomes.pop_front();
                    if (status !== exp_o.status) begin
                        $error("status expected %0d actual %0d", exp_o.status, status);
                        failures++;
                    end
                    if (slot !== exp_o.slot) begin
                        $error("slot expected %0d actual %0d", exp_o.slot, slot);
                        failures++;
                    end
                    if (out_src_ip !== exp_o.src_ip) begin
                        $error("out_src_ip expected %h actual %h", exp_o.src_ip, out_src_ip);
                        failures++;
                    end
                    if (out_src_port !== exp_o.src_port) begin
                        $error("out_src_port expected %h actual %h", exp_o.src_port,
                               out_src_port);
                        failures++;
                    end
                    if (data_len !== exp_o.data_len) begin
                        $error("data_len expected %0d actual %0d", exp_o.data_len, data_len);
                        failures++;
                    end
                end
                gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                gap--;
            end else
                out_stall <= ($urandom_range(7) == 0);
        end
    end

    // The previous request stays on the pins after acceptance; it is only
    // withdrawn when an idle gap follows, so valid is written once per edge.
    task automatic send_request(request_t r);
        int gap;
        gap = $urandom_range(2) == 0 ? 0 : $urandom_range(6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= r.op;
        frame_len   <= r.frame_len;
        ethertype   <= r.ethertype;
        ip_protocol <= r.ip_protocol;
        ihl         <= r.ihl;
        port        <= r.port;
        src_port    <= r.src_port;
        udp_len     <= r.udp_len;
        src_ip      <= r.src_ip;
        icmp_type   <= r.icmp_type;
        inner_port  <= r.inner_port;
        max_len     <= r.max_len;
        do @(posedge clk); while (in_stall);
        pending_outcomes.push_back(predict_outcome(r));
    endtask

    function automatic request_t blank_request(op_t o, logic [15:0] p);
        request_t r;
        r = '{o, 12'd60, ETYPE_IPV4, PROTO_UDP, 4'd5, p, 16'($urandom()), 16'($urandom()),
              $urandom(), 8'($urandom()), 16'($urandom()), 16'($urandom())};
        return r;
    endfunction

    function automatic request_t udp_request(logic [15:0] p, logic [15:0] ulen);
        request_t r;
        r = blank_request(OP_PACKET, p);
        r.udp_len = ulen;
        r.frame_len = 12'($urandom_range(4095, 42));
        return r;
    endfunction

    function automatic request_t icmp_request(logic [7:0] t, logic [15:0] ip);
        request_t r;
        r = blank_request(OP_PACKET, 16'($urandom()));
        r.ip_protocol = PROTO_ICMP;
        r.icmp_type = t;
        r.inner_port = ip;
        return r;
    endfunction

    task automatic test_directed();
        request_t r;
        r = blank_request(OP_PACKET, 16'd0);
        r.ethertype = ETYPE_ARP;
        r.frame_len = 12'd41;
        send_request(r);
        r.frame_len = 12'd42;
        send_request(r);
        send_request(r);
        r = blank_request(OP_PACKET, 16'd0);
        r.frame_len = 12'd33;
        send_request(r);
        send_request(blank_request(OP_BIND, 16'hffff));
        send_request(blank_request(OP_BIND, 16'd0));
        send_request(blank_request(OP_BIND, 16'(NPORTS-1)));
        send_request(udp_request(16'd0, 16'd0));
        send_request(udp_request(16'd0, 16'hffff));
        send_request(udp_request(16'(NPORTS-1), 16'd520));
        r = udp_request(16'd0, 16'd30);
        r.ihl = 4'd4;
        send_request(r);
        r = udp_request(16'd0, 16'd30);
        r.ihl = 4'd15;
        r.frame_len = 12'd81;
        send_request(r);
        r.frame_len = 12'd82;
        send_request(r);
        send_request(udp_request(16'd5, 16'd40));
        send_request(icmp_request(ICMP_TYPE_ECHO, 16'd0));
        send_request(icmp_request(ICMP_UNREACH, 16'd0));
        send_request(icmp_request(ICMP_TIMEX, 16'hffff));
        send_request(icmp_request(8'd0, 16'd0));
        r = icmp_request(ICMP_TYPE_ECHO, 16'd0);
        r.ihl = 4'd15;
        r.frame_len = 12'd81;
        send_request(r);
        r = blank_request(OP_RECV, 16'd0);
        send_request(r);
        r.max_len = 16'd0;
        send_request(r);
        r.max_len = 16'hffff;
        send_request(r);
        send_request(blank_request(OP_RECV, 16'd7));
        send_request(blank_request(OP_UNBIND, 16'(NPORTS-1)));
        send_request(blank_request(OP_RECV, 16'(NPORTS-1)));
    endtask

    // Mostly well-formed traffic on a few ports so queues fill, wrap and drain.
    task automatic test_random_traffic(int count);
        request_t r;
        int       sel;
        logic [15:0] p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(9) == 0 ? 16'($urandom())
                : 16'($urandom_range(3) + 60*($urandom_range(1)));
            sel = $urandom_range(99);
            if (sel < 40) begin
                r = udp_request(p, $urandom_range(3) == 0 ? 16'($urandom())
                                   : 16'($urandom_range(540)));
                if ($urandom_range(9) == 0) r.ihl = 4'($urandom());
                if ($urandom_range(9) == 0) r.ip_protocol = 8'($urandom());
            end else if (sel < 70)
                r = blank_request(OP_RECV, p);
            else if (sel < 78)
                r = blank_request(OP_BIND, p);
            else if (sel < 82)
                r = blank_request(OP_UNBIND, p);
            else if (sel < 90) begin
                r = icmp_request($urandom_range(1) ? ICMP_TYPE_QUENCH : 8'($urandom()), p);
                r.frame_len = 12'($urandom());
                r.ihl = 4'($urandom());
            end else begin
                r = blank_request(OP_PACKET, 16'($urandom()));
                r.frame_len = 12'($urandom());
                r.ethertype = $urandom_range(1) ? ETYPE_ARP : 16'($urandom());
            end
            send_request(r);
        end
    endtask

    initial begin : stimulus
        failures = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = '0; frame_len = '0; ethertype = '0; ip_protocol = '0; ihl = '0;
        port = '0; src_port = '0; udp_len = '0; src_ip = '0; icmp_type = '0;
        inner_port = '0; max_len = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(1750);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("udp_port_demux_queues test passed");
        else
            $display("udp_port_demux_queues test failed");
        $finish;
    end
endmodule
